/* sv/nmgp_pkg.sv */
// Shared types and constants for the NMEA GGA/GSA/GSV sentence parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nmgp_pkg;

	localparam int MSG_LEN_MAX_DEF = 256;
	localparam int EVT_DEPTH       = 4;
	localparam int RES_DEPTH       = 2;

	localparam logic [29:0] ACC_MAX = 30'd1073741823;
	localparam logic [26:0] LAT_MAX = 27'd99999999;
	localparam logic [29:0] LON_MAX = 30'd999999999;

	typedef enum logic [2:0] {
		SYS_UNKNOWN = 3'd0,
		SYS_GPS     = 3'd1,
		SYS_GLONASS = 3'd2,
		SYS_BEIDOU  = 3'd3,
		SYS_GALILEO = 3'd4,
		SYS_MULTI   = 3'd5,
		TALK_DOLLAR = 3'd6,
		TALK_G      = 3'd7
	} sys_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_GGA   = 2'd1,
		KIND_GSV   = 2'd2,
		KIND_GSA   = 2'd3
	} kind_t;

	// one field close, optionally followed by an empty-field close and the sentence end
	typedef struct packed {
		logic        last;
		logic        zero_en;
		kind_t       kind;
		sys_t        sys;
		logic [4:0]  fld;
		logic [4:0]  fld_next;
		logic [29:0] acc;
		logic [2:0]  fd;
		logic [8:0]  whole;
	} evt_t;

	typedef struct packed {
		sys_t        sys;
		kind_t       kind;
		logic        fix;
		logic [7:0]  count;
		logic [26:0] lat;
		logic [29:0] lon;
	} res_t;

endpackage

`default_nettype wire

/* sv/nmea_gnss_sentence_parser_top.sv */
// A result passes through the event queue and then the result queue; it waits behind
// any events queued ahead of it and while the result queue is full.
// Throughput: one byte per cycle; the front stalls only when its 4-entry event
// queue is full, which happens when the 2-entry result queue is not popped.
// Reset: arst_n asynchronously clears sentence state, kept status and queues.
// Depends on nmgp_pkg, nmgp_front, nmgp_back, nmgp_fifo.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gnss_sentence_parser_top #(
	parameter int MSG_LEN_MAX = nmgp_pkg::MSG_LEN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  constellation,
	output logic [1:0]  sentence_kind,
	output logic        fix_valid,
	output logic [7:0]  satellites,
	output logic [26:0] latitude_e4,
	output logic [29:0] longitude_e4
);
	import nmgp_pkg::*;

	localparam int EVT_W = $bits(evt_t);
	localparam int RES_W = $bits(res_t);

	logic accept;
	evt_t evt_in, evt_head;
	logic evt_push, evt_pop, evt_empty;
	logic [EVT_W-1:0] evt_rdata;
	res_t res_in, res_head;
	logic res_push, res_full;
	logic [RES_W-1:0] res_rdata;

	assign accept = push && !full;

	nmgp_front #(.MSG_LEN_MAX(MSG_LEN_MAX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_byte (char_byte),
		.last_byte (last_byte),
		.evt       (evt_in),
		.evt_push  (evt_push)
	);

	nmgp_fifo #(.WIDTH(EVT_W), .DEPTH(EVT_DEPTH)) u_evt_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (evt_push),
		.wdata  (evt_in),
		.pop    (evt_pop),
		.rdata  (evt_rdata),
		.full   (full),
		.empty  (evt_empty)
	);

	assign evt_head = evt_t'(evt_rdata);

	nmgp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_head),
		.evt_valid (!evt_empty),
		.evt_pop   (evt_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	nmgp_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty)
	);

	assign res_head      = res_t'(res_rdata);
	assign constellation = res_head.sys;
	assign sentence_kind = res_head.kind;
	assign fix_valid     = res_head.fix;
	assign satellites    = res_head.count;
	assign latitude_e4   = res_head.lat;
	assign longitude_e4  = res_head.lon;

	a_res_only_from_events: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && evt_empty) |=> empty)
		else $error("result appeared without a queued event");

	a_sys_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (constellation <= 3'd5))
		else $error("constellation code out of range");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (latitude_e4 <= LAT_MAX && longitude_e4 <= LON_MAX))
		else $error("position not saturated");

endmodule

`default_nettype wire

/* sv/nmgp_fifo.sv */
// Small register queue used between front and back and for results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nmgp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/nmgp_front.sv */
// Front end: header decode, field split and decimal accumulation per byte.
// Depends on nmgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmgp_front #(
	parameter int MSG_LEN_MAX = nmgp_pkg::MSG_LEN_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    char_byte,
	input  logic          last_byte,
	output nmgp_pkg::evt_t evt,
	output logic          evt_push
);
	import nmgp_pkg::*;

	localparam int POS_W = $clog2(MSG_LEN_MAX + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MSG_LEN_MAX);
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [4:0] FLD_MAX   = 5'd31;
	localparam logic [8:0] INT_SAT   = 9'd256;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [4:0]       fld_q, fld_n;
	sys_t             talk_q, talk_n;
	kind_t            kind_q, kind_n, kind_now;
	logic [29:0]      acc_q, acc_n;
	logic [2:0]       fd_q, fd_n;
	logic [8:0]       int_q, int_n;
	logic             pt_q, pt_n, ended_q, ended_n;
	logic             pos_ok, is_sep, is_dig;
	logic [3:0]       digit;
	logic [33:0]      acc_x10;
	logic [11:0]      int_x10;

	always_comb begin
		pos_ok  = (pos_q < POS_LIMIT);
		is_sep  = (char_byte == CH_COMMA) || (char_byte == CH_STAR);
		is_dig  = char_byte inside {[CH_0:CH_9]};
		digit   = char_byte[3:0];
		acc_x10 = {4'b0, acc_q} * 34'd10 + 34'(digit);
		int_x10 = {3'b0, int_q} * 12'd10 + 12'(digit);

		talk_n = talk_q;
		kind_n = kind_q;
		if (pos_ok) begin
			case (pos_q)
				POS_W'(0): talk_n = (char_byte == CH_DOLLAR) ? TALK_DOLLAR : SYS_UNKNOWN;
				POS_W'(1): talk_n = (talk_q == TALK_DOLLAR && char_byte == CH_G) ?
				                    TALK_G : SYS_UNKNOWN;
				POS_W'(2): begin
					talk_n = SYS_UNKNOWN;
					if (talk_q == TALK_G) begin
						case (char_byte)
							CH_P:    talk_n = SYS_GPS;
							CH_L:    talk_n = SYS_GLONASS;
							CH_B:    talk_n = SYS_BEIDOU;
							CH_A:    talk_n = SYS_GALILEO;
							CH_N:    talk_n = SYS_MULTI;
							default: talk_n = SYS_UNKNOWN;
						endcase
					end
				end
				// 'G' at byte 3 parks the GSA code as an interim marker
				POS_W'(3): kind_n = (char_byte == CH_G) ? KIND_GSA : KIND_OTHER;
				POS_W'(4): begin
					if (kind_q == KIND_GSA && char_byte == CH_G) kind_n = KIND_GGA;
					else if (kind_q == KIND_GSA && char_byte == CH_S) kind_n = KIND_GSV;
					else kind_n = KIND_OTHER;
				end
				POS_W'(5): begin
					if (kind_q == KIND_GGA && char_byte == CH_A) kind_n = KIND_GGA;
					else if (kind_q == KIND_GSV && char_byte == CH_V) kind_n = KIND_GSV;
					else if (kind_q == KIND_GSV && char_byte == CH_A) kind_n = KIND_GSA;
					else kind_n = KIND_OTHER;
				end
				default: ;
			endcase
		end

		acc_n   = acc_q;
		fd_n    = fd_q;
		int_n   = int_q;
		pt_n    = pt_q;
		ended_n = ended_q;
		if (pos_ok && !is_sep && !ended_q) begin
			if (is_dig) begin
				if (!(pt_q && fd_q >= 3'd4)) begin
					acc_n = (acc_x10 > 34'(ACC_MAX)) ? ACC_MAX : acc_x10[29:0];
					if (pt_q) begin
						fd_n = fd_q + 3'd1;
					end else begin
						int_n = (int_x10 > 12'd255) ? INT_SAT : int_x10[8:0];
					end
				end
			end else if (char_byte == CH_DOT && !pt_q) begin
				pt_n = 1'b1;
			end else begin
				ended_n = 1'b1;
			end
		end

		fld_n    = (pos_ok && is_sep && fld_q != FLD_MAX) ? fld_q + 5'd1 : fld_q;
		pos_n    = pos_ok ? pos_q + 1'b1 : pos_q;
		kind_now = (pos_n >= POS_W'(6)) ? kind_n : KIND_OTHER;

		evt.last     = last_byte;
		evt.zero_en  = last_byte && pos_ok && is_sep;
		evt.kind     = kind_now;
		evt.sys      = (talk_n <= SYS_MULTI) ? talk_n : SYS_UNKNOWN;
		evt.fld      = fld_q;
		evt.fld_next = fld_n;
		evt.acc      = acc_n;
		evt.fd       = fd_n;
		evt.whole    = int_n;
		evt_push     = accept && ((pos_ok && is_sep) || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fld_q   <= '0;
			talk_q  <= SYS_UNKNOWN;
			kind_q  <= KIND_OTHER;
			acc_q   <= '0;
			fd_q    <= '0;
			int_q   <= '0;
			pt_q    <= 1'b0;
			ended_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q   <= '0;
				fld_q   <= '0;
				talk_q  <= SYS_UNKNOWN;
				kind_q  <= KIND_OTHER;
				acc_q   <= '0;
				fd_q    <= '0;
				int_q   <= '0;
				pt_q    <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				fld_q  <= fld_n;
				talk_q <= talk_n;
				kind_q <= kind_n;
				if (pos_ok && is_sep) begin
					acc_q   <= '0;
					fd_q    <= '0;
					int_q   <= '0;
					pt_q    <= 1'b0;
					ended_q <= 1'b0;
				end else begin
					acc_q   <= acc_n;
					fd_q    <= fd_n;
					int_q   <= int_n;
					pt_q    <= pt_n;
					ended_q <= ended_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/nmgp_back.sv */
// Back end: applies field closes to pending values, updates kept status at
// sentence end and produces the result. Depends on nmgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmgp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  nmgp_pkg::evt_t evt,
	input  logic           evt_valid,
	output logic           evt_pop,
	output nmgp_pkg::res_t res,
	output logic           res_push,
	input  logic           res_full
);
	import nmgp_pkg::*;

	localparam logic [4:0] F_GGA_LAT = 5'd2;
	localparam logic [4:0] F_GGA_LON = 5'd4;
	localparam logic [4:0] F_GGA_FIX = 5'd6;
	localparam logic [4:0] F_GGA_CNT = 5'd7;
	localparam logic [4:0] F_GSV_CNT = 5'd3;
	localparam logic [4:0] F_GSA_FIX = 5'd2;

	function automatic logic [13:0] scale_e4(input logic [2:0] fd);
		case (fd)
			3'd0:    scale_e4 = 14'd10000;
			3'd1:    scale_e4 = 14'd1000;
			3'd2:    scale_e4 = 14'd100;
			3'd3:    scale_e4 = 14'd10;
			default: scale_e4 = 14'd1;
		endcase
	endfunction

	logic        pfix_q, pfix_n, kfix_q, kfix_n;
	logic [7:0]  pcnt_q, pcnt_n, kcnt_q, kcnt_n;
	logic [26:0] plat_q, plat_n, klat_q, klat_n;
	logic [29:0] plon_q, plon_n, klon_q, klon_n;
	logic [43:0] e4;
	logic [26:0] lat_v;
	logic [29:0] lon_v;
	logic [7:0]  cnt_v;

	always_comb begin
		e4    = {14'b0, evt.acc} * {30'b0, scale_e4(evt.fd)};
		lat_v = (e4 > 44'(LAT_MAX)) ? LAT_MAX : e4[26:0];
		lon_v = (e4 > 44'(LON_MAX)) ? LON_MAX : e4[29:0];
		cnt_v = (evt.whole > 9'd255) ? 8'd255 : evt.whole[7:0];

		pfix_n = pfix_q;
		pcnt_n = pcnt_q;
		plat_n = plat_q;
		plon_n = plon_q;
		case (evt.kind)
			KIND_GGA: begin
				if (evt.fld == F_GGA_LAT) plat_n = lat_v;
				if (evt.fld == F_GGA_LON) plon_n = lon_v;
				if (evt.fld == F_GGA_FIX) pfix_n = (evt.whole != 9'd0);
				if (evt.fld == F_GGA_CNT) pcnt_n = cnt_v;
				if (evt.zero_en) begin
					if (evt.fld_next == F_GGA_LAT) plat_n = '0;
					if (evt.fld_next == F_GGA_LON) plon_n = '0;
					if (evt.fld_next == F_GGA_FIX) pfix_n = 1'b0;
					if (evt.fld_next == F_GGA_CNT) pcnt_n = '0;
				end
			end
			KIND_GSV: begin
				if (evt.fld == F_GSV_CNT) pcnt_n = cnt_v;
				if (evt.zero_en && evt.fld_next == F_GSV_CNT) pcnt_n = '0;
			end
			KIND_GSA: begin
				if (evt.fld == F_GSA_FIX) pfix_n = (evt.whole > 9'd1);
				if (evt.zero_en && evt.fld_next == F_GSA_FIX) pfix_n = 1'b0;
			end
			default: ;
		endcase

		kfix_n = kfix_q;
		kcnt_n = kcnt_q;
		klat_n = klat_q;
		klon_n = klon_q;
		if (evt.kind == KIND_GGA && evt.fld_next >= 5'd7) begin
			kfix_n = pfix_n;
			kcnt_n = pcnt_n;
			klat_n = plat_n;
			klon_n = plon_n;
		end else if (evt.kind == KIND_GSV && evt.fld_next >= 5'd3) begin
			kcnt_n = pcnt_n;
		end else if (evt.kind == KIND_GSA && evt.fld_next >= 5'd2) begin
			kfix_n = pfix_n;
		end

		evt_pop   = evt_valid && (!evt.last || !res_full);
		res_push  = evt_pop && evt.last;
		res.sys   = evt.sys;
		res.kind  = evt.kind;
		res.fix   = kfix_n;
		res.count = kcnt_n;
		res.lat   = klat_n;
		res.lon   = klon_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfix_q <= 1'b0;
			pcnt_q <= '0;
			plat_q <= '0;
			plon_q <= '0;
			kfix_q <= 1'b0;
			kcnt_q <= '0;
			klat_q <= '0;
			klon_q <= '0;
		end else if (evt_pop) begin
			if (evt.last) begin
				pfix_q <= 1'b0;
				pcnt_q <= '0;
				plat_q <= '0;
				plon_q <= '0;
				kfix_q <= kfix_n;
				kcnt_q <= kcnt_n;
				klat_q <= klat_n;
				klon_q <= klon_n;
			end else begin
				pfix_q <= pfix_n;
				pcnt_q <= pcnt_n;
				plat_q <= plat_n;
				plon_q <= plon_n;
			end
		end
	end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for nmea_gnss_sentence_parser_top: sentence bytes in, kept status out.
// An in-bench parser predicts each result and a scoreboard checks them field by field.
// Depends on nmgp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
	import nmgp_pkg::*;

	localparam int MSG_LEN        = MSG_LEN_MAX_DEF;
	localparam int HDR_LEN        = 6;
	localparam int FLD_MAX        = 31;
	localparam int FLD_LAT        = 2;
	localparam int FLD_LON        = 4;
	localparam int FLD_FIX        = 6;
	localparam int FLD_SATS       = 7;
	localparam int FLD_GSV_SATS   = 3;
	localparam int FLD_GSA_MODE   = 2;
	localparam int RAND_BYTES     = 1250;
	localparam int QUIET_AFTER    = 1050;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	logic [7:0]  char_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop       = 1'b0;
	logic [2:0]  constellation;
	logic [1:0]  sentence_kind;
	logic        fix_valid;
	logic [7:0]  satellites;
	logic [26:0] latitude_e4;
	logic [29:0] longitude_e4;

	logic [7:0]  sentence_q[$];
	bit          quiet = 1'b0;
	int          rand_bytes = 0;

	class sentence_scoreboard;
		int          pos;
		logic [4:0]  fld;
		sys_t        talker;
		kind_t       kind_c;
		logic [29:0] acc;
		logic [2:0]  fd;
		bit          pt;
		bit          ended;
		bit          p_fix;
		logic [7:0]  p_count;
		logic [26:0] p_lat;
		logic [29:0] p_lon;
		sys_t        k_sys;
		bit          k_fix;
		logic [7:0]  k_count;
		logic [26:0] k_lat;
		logic [29:0] k_lon;
		res_t        expected_q[$];
		int          errors;

		function new();
			clear_sentence();
			k_sys = SYS_UNKNOWN;
			k_fix = 1'b0;
			k_count = '0;
			k_lat = '0;
			k_lon = '0;
			errors = 0;
		endfunction

		function void clear_number();
			acc = '0;
			fd = '0;
			pt = 1'b0;
			ended = 1'b0;
		endfunction

		function void clear_sentence();
			pos = 0;
			fld = '0;
			talker = SYS_UNKNOWN;
			kind_c = KIND_OTHER;
			clear_number();
			p_fix = 1'b0;
			p_count = '0;
			p_lat = '0;
			p_lon = '0;
		endfunction

		function longint unsigned sat(longint unsigned v, longint unsigned cap);
			return (v > cap) ? cap : v;
		endfunction

		function kind_t cur_kind();
			if (pos >= HDR_LEN)
				return kind_c;
			return KIND_OTHER;
		endfunction

		function void close_field();
			longint unsigned whole;
			longint unsigned e4;
			kind_t k;
			whole = acc;
			e4 = acc;
			k = cur_kind();
			for (int i = 0; i < fd; i++)
				whole = whole / 10;
			for (int i = fd; i < 4; i++)
				e4 = e4 * 10;
			case (k)
			KIND_GGA: begin
				if (fld == FLD_LAT)
					p_lat = 27'(sat(e4, LAT_MAX));
				else if (fld == FLD_LON)
					p_lon = 30'(sat(e4, LON_MAX));
				else if (fld == FLD_FIX)
					p_fix = (whole > 0);
				else if (fld == FLD_SATS)
					p_count = 8'(sat(whole, 255));
			end
			KIND_GSV: begin
				if (fld == FLD_GSV_SATS)
					p_count = 8'(sat(whole, 255));
			end
			KIND_GSA: begin
				if (fld == FLD_GSA_MODE)
					p_fix = (whole > 1);
			end
			default: ;
			endcase
		endfunction

		function void feed_char(logic [7:0] c);
			longint unsigned v;
			if (ended)
				return;
			if (c >= "0" && c <= "9") begin
				if (pt && fd >= 4)
					return;
				v = longint'(acc) * 10 + longint'(c - "0");
				acc = 30'(sat(v, ACC_MAX));
				if (pt)
					fd++;
			end else if (c == "." && !pt) begin
				pt = 1'b1;
			end else begin
				ended = 1'b1;
			end
		endfunction

		// header decode by position; KIND_GSA doubles as "G seen" at byte 3
		function void header_char(int p, logic [7:0] c);
			case (p)
			0: begin
				if (c == "$") talker = TALK_DOLLAR;
				else talker = SYS_UNKNOWN;
			end
			1: begin
				if (talker == TALK_DOLLAR && c == "G") talker = TALK_G;
				else talker = SYS_UNKNOWN;
			end
			2: begin
				if (talker != TALK_G) talker = SYS_UNKNOWN;
				else if (c == "P") talker = SYS_GPS;
				else if (c == "L") talker = SYS_GLONASS;
				else if (c == "B") talker = SYS_BEIDOU;
				else if (c == "A") talker = SYS_GALILEO;
				else if (c == "N") talker = SYS_MULTI;
				else talker = SYS_UNKNOWN;
			end
			3: begin
				if (c == "G") kind_c = KIND_GSA;
				else kind_c = KIND_OTHER;
			end
			4: begin
				if (kind_c == KIND_GSA && c == "G") kind_c = KIND_GGA;
				else if (kind_c == KIND_GSA && c == "S") kind_c = KIND_GSV;
				else kind_c = KIND_OTHER;
			end
			5: begin
				if (kind_c == KIND_GGA && c == "A") kind_c = KIND_GGA;
				else if (kind_c == KIND_GSV && c == "V") kind_c = KIND_GSV;
				else if (kind_c == KIND_GSV && c == "A") kind_c = KIND_GSA;
				else kind_c = KIND_OTHER;
			end
			default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] c, logic last);
			res_t r;
			kind_t k;
			if (pos < MSG_LEN) begin
				header_char(pos, c);
				pos++;
				if (c == "," || c == "*") begin
					close_field();
					if (fld != FLD_MAX)
						fld++;
					clear_number();
				end else begin
					feed_char(c);
				end
			end
			if (!last)
				return;
			close_field();
			k = cur_kind();
			if (k == KIND_GGA && fld >= FLD_SATS) begin
				k_fix = p_fix;
				k_count = p_count;
				k_lat = p_lat;
				k_lon = p_lon;
			end else if (k == KIND_GSV && fld >= FLD_GSV_SATS) begin
				k_count = p_count;
			end else if (k == KIND_GSA && fld >= FLD_GSA_MODE) begin
				k_fix = p_fix;
			end
			if (talker <= SYS_MULTI) k_sys = talker;
			else k_sys = SYS_UNKNOWN;
			r.sys = k_sys;
			r.kind = k;
			r.fix = k_fix;
			r.count = k_count;
			r.lat = k_lat;
			r.lon = k_lon;
			expected_q.push_back(r);
			clear_sentence();
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void cmp(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, name, e, a);
			end
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual sys %0d kind %0d",
					$time, got.sys, got.kind);
				return;
			end
			e = expected_q.pop_front();
			cmp("constellation", e.sys, got.sys);
			cmp("sentence_kind", e.kind, got.kind);
			cmp("fix_valid", e.fix, got.fix);
			cmp("satellites", e.count, got.count);
			cmp("latitude_e4", e.lat, got.lat);
			cmp("longitude_e4", e.lon, got.lon);
		endfunction
	endclass

	sentence_scoreboard sb = new();

	nmea_gnss_sentence_parser_top #(
		.MSG_LEN_MAX(MSG_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_byte(char_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.constellation(constellation),
		.sentence_kind(sentence_kind),
		.fix_valid(fix_valid),
		.satellites(satellites),
		.latitude_e4(latitude_e4),
		.longitude_e4(longitude_e4)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function void add_str(string s);
		for (int i = 0; i < s.len(); i++)
			sentence_q.push_back(s[i]);
	endfunction

	function void add_digits(int n);
		for (int i = 0; i < n; i++)
			sentence_q.push_back(8'("0" + $urandom_range(0, 9)));
	endfunction

	function void add_field();
		string letters;
		string junk;
		letters = "NSEWMA";
		junk = "-+/A";
		case ($urandom_range(0, 9))
		0: ;
		1: add_digits(1);
		2, 3: add_digits($urandom_range(1, 3));
		4, 5: begin
			add_digits($urandom_range(1, 5));
			add_str(".");
			add_digits($urandom_range(0, 6));
		end
		6: add_digits($urandom_range(8, 12));
		7: sentence_q.push_back(letters[$urandom_range(0, 5)]);
		8: begin
			add_digits($urandom_range(0, 3));
			sentence_q.push_back(junk[$urandom_range(0, 3)]);
			add_digits(2);
		end
		default: begin
			add_digits(2);
			add_str(".");
			add_digits(1);
			add_str(".");
			add_digits(2);
		end
		endcase
	endfunction

	function void build_wellformed();
		int nf;
		add_str("$");
		case ($urandom_range(0, 6))
		0: add_str("GP");
		1: add_str("GL");
		2: add_str("GB");
		3: add_str("GA");
		4: add_str("GN");
		5: add_str("BD");
		default: begin
			sentence_q.push_back("G");
			sentence_q.push_back(8'("A" + $urandom_range(0, 25)));
		end
		endcase
		case ($urandom_range(0, 7))
		0, 1, 2: add_str("GGA");
		3, 4: add_str("GSV");
		5: add_str("GSA");
		6: add_str("RMC");
		default: begin
			add_str("GS");
			sentence_q.push_back(8'("A" + $urandom_range(0, 25)));
		end
		endcase
		nf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(7, 14);
		for (int i = 0; i < nf; i++) begin
			add_str(",");
			add_field();
		end
		case ($urandom_range(0, 5))
		0: ;
		1: begin
			add_str("*");
			add_str($sformatf("%02X", $urandom_range(0, 255)));
		end
		2: begin
			add_str("*");
			add_str($sformatf("%02X", $urandom_range(0, 255)));
			sentence_q.push_back(CHAR_CR);
			sentence_q.push_back(CHAR_LF);
		end
		3: add_str(",");
		4: add_str("*");
		default: begin
			sentence_q.push_back(CHAR_CR);
			sentence_q.push_back(CHAR_LF);
		end
		endcase
	endfunction

	function void build_broken();
		int n;
		case ($urandom_range(0, 3))
		0: begin
			build_wellformed();
			n = $urandom_range(1, 6);
			while (sentence_q.size() > n)
				void'(sentence_q.pop_back());
		end
		1: begin
			build_wellformed();
			sentence_q[0] = 8'($urandom_range(0, 255));
		end
		2: begin
			n = $urandom_range(1, 20);
			repeat (n) sentence_q.push_back(8'($urandom_range(0, 255)));
		end
		default: begin
			build_wellformed();
			sentence_q[$urandom_range(0, sentence_q.size() - 1)] = 8'($urandom_range(0, 255));
		end
		endcase
	endfunction

	function void build_overlong();
		int target;
		target = MSG_LEN + $urandom_range(1, 40);
		if ($urandom_range(0, 1)) add_str("$GPGGA");
		else add_str("$GNGSV");
		while (sentence_q.size() < target) begin
			add_str(",");
			add_field();
		end
	endfunction

	task send_byte(input logic [7:0] c, input logic l, input bit gappy);
		bit ok;
		if (gappy && !quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		push <= 1'b1;
		char_byte <= c;
		last_byte <= l;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		sb.note_byte(c, l);
	endtask

	task send_sentence(input bit gappy);
		for (int i = 0; i < sentence_q.size(); i++)
			send_byte(sentence_q[i], i == sentence_q.size() - 1, gappy);
	endtask

	task drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	// result side: sample mid-cycle, check at the accepting edge
	initial begin
		res_t got;
		bit fire;
		bit calm;
		int stall;
		stall = 0;
		calm = 1'b0;
		forever begin
			@(negedge clk);
			fire = pop && !empty;
			got.sys = sys_t'(constellation);
			got.kind = kind_t'(sentence_kind);
			got.fix = fix_valid;
			got.count = satellites;
			got.lat = latitude_e4;
			got.lon = longitude_e4;
			@(posedge clk);
			if (fire)
				sb.check_result(got);
			if ($urandom_range(0, 99) == 0)
				calm = !calm;
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int n_sent;
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// GSA with empty field 1, GSV count saturation, GGA with lat saturation and
		// over-long fraction, then a headerless sentence with byte extremes
		sentence_q.delete();
		add_str("$GNGSA,,3");
		send_sentence(1'b0);
		sentence_q.delete();
		add_str("$GLGSV,,,9999999999,");
		send_sentence(1'b0);
		sentence_q.delete();
		add_str("$GAGGA,,99999.9,,1.2345678,,2,7");
		send_sentence(1'b0);
		sentence_q.delete();
		sentence_q = {8'hFF, 8'h24, 8'h00};
		send_sentence(1'b0);
		drain();

		n_sent = 0;
		while (rand_bytes < RAND_BYTES) begin
			sentence_q.delete();
			r = $urandom_range(0, 99);
			if (n_sent == 3 || r < 2)
				build_overlong();
			else if (r < 82)
				build_wellformed();
			else
				build_broken();
			rand_bytes += sentence_q.size();
			quiet = (rand_bytes >= QUIET_AFTER);
			send_sentence($urandom_range(0, 2) != 0);
			n_sent++;
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
